FILE: sv/sigrl_pkg.sv
// Package for the signature rate limiter: word types, the sequencer state type,
// FNV-1a constants, configuration register indexes and their reset values.
// No dependencies.
package sigrl_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int SIG_W  = 32;
    localparam int CNT_W  = 8;
    localparam int SLOT_W = SIG_W + CNT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_CAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSCALL_OP = 2'd2;

    localparam logic [15:0] RST_RUN_BUDGET = 16'd256;
    localparam logic [7:0]  RST_SIG_CAP    = 8'd8;
    localparam logic [31:0] RST_SYSCALL_OP = 32'd0;

    typedef struct packed {
        logic [31:0] op_type;
        logic [31:0] call_number;
        logic        snapshot_ok;
        logic [7:0]  name_byte;
        logic        byte_present;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic        grant_print;
        logic        budget_notice;
        logic        snapshot_giveup;
        logic [15:0] printed_count;
        logic [31:0] omitted_count;
        logic [7:0]  signatures_used;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOP,
        S_HCALL,
        S_HBYTE,
        S_MOD,
        S_RD,
        S_CHK
    } t_state;

endpackage

FILE: sv/sigrl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sigrl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/signature_rate_limiter.sv
// Signature rate limiter top level: FNV-1a signature sequencer, linear-probe
// table lookup and print budget gate. Uses sigrl_pkg and sigrl_ram.
// Flow: the first word of a request takes three folds through the shared multiplier
// (op type, call number, name byte if present); later words fold only the name byte.
// A last word then finds the start slot by reciprocal remainder and reads the table
// once per probe. Reset clears control state and then sweeps the table, one slot per
// cycle over all TABLE_SLOTS slots, during which no word is accepted.
module signature_rate_limiter #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sigrl_pkg::t_in_word                 i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sigrl_pkg::t_out_word                o_out_word,
    input  logic                                i_cfg_we,
    input  logic [sigrl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sigrl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int SF_W   = $clog2(TABLE_SLOTS + 1);
    localparam int SF_X   = (SF_W > 8) ? SF_W : 8;
    localparam logic [31:0]      TS_W     = 32'(TABLE_SLOTS);
    localparam logic [31:0]      TS_RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_SLOTS));
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    sigrl_pkg::t_state r_state, n_state;

    logic [15:0] r_budget;
    logic [7:0]  r_cap;
    logic [31:0] r_sys_op;

    logic        r_mid;
    logic [31:0] r_op;
    logic [31:0] r_call;
    logic        r_giveup;
    logic [7:0]  r_byte;
    logic        r_present;
    logic        r_last;
    logic [31:0] r_hash;
    logic [31:0] r_sig;
    logic [31:0] r_mod;
    logic [1:0]  r_bit;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_probe;

    logic [15:0]     r_granted;
    logic [31:0]     r_refused;
    logic [SF_W-1:0] r_slots;
    logic            r_notice_given;

    logic                 r_out_valid;
    sigrl_pkg::t_out_word r_out;

    logic                         w_accept;
    logic [31:0]                  w_operand;
    logic [31:0]                  w_fold;
    logic [31:0]                  w_hash_end;
    logic [63:0]                  w_recip_prod;
    logic [31:0]                  w_quo_lo;
    logic [31:0]                  w_mod_r0;
    logic                         w_mod_ge;
    logic [31:0]                  w_mod_nx;
    logic [sigrl_pkg::SLOT_W-1:0] w_rdata;
    logic [31:0]                  w_rd_sig;
    logic [7:0]                   w_rd_cnt;
    logic                         w_empty;
    logic                         w_match;
    logic                         w_last_probe;
    logic                         w_final;
    logic                         w_budget_ok;
    logic                         w_capped;
    logic                         w_gate;
    logic                         w_grant;
    logic                         w_notice;
    logic                         w_out_free;
    logic                         w_decide;
    logic [15:0]                  w_granted_nx;
    logic [31:0]                  w_refused_nx;
    logic [SF_W-1:0]              w_slots_nx;
    logic [SF_X-1:0]              w_slots_ext;
    logic                         w_ram_we;
    logic [sigrl_pkg::SLOT_W-1:0] w_ram_wdata;

    sigrl_ram #(
        .WIDTH (sigrl_pkg::SLOT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_accept = i_in_valid && !o_in_stall;

    // The one shared FNV fold unit: xor then multiply by the prime.
    always_comb begin
        case (r_state)
            sigrl_pkg::S_HOP:   w_operand = r_op;
            sigrl_pkg::S_HCALL: w_operand = r_call;
            default:            w_operand = {24'd0, r_byte};
        endcase
    end

    assign w_fold     = (r_hash ^ w_operand) * sigrl_pkg::FNV_PRIME;
    assign w_hash_end = r_present ? w_fold : r_hash;

    // The reciprocal quotient is exact or one short, so one subtract finishes the remainder.
    assign w_recip_prod = 64'(r_sig) * 64'(TS_RECIP);
    assign w_quo_lo     = r_mod * TS_W;
    assign w_mod_r0     = r_sig - w_quo_lo;
    assign w_mod_ge     = r_mod >= TS_W;
    assign w_mod_nx     = w_mod_ge ? (r_mod - TS_W) : r_mod;

    assign w_rd_sig     = w_rdata[sigrl_pkg::SLOT_W-1:sigrl_pkg::CNT_W];
    assign w_rd_cnt     = w_rdata[sigrl_pkg::CNT_W-1:0];
    assign w_empty      = w_rd_sig == 32'd0;
    assign w_match      = w_rd_sig == r_sig;
    assign w_last_probe = r_probe == IDX_LAST;
    assign w_final      = w_empty || w_match || w_last_probe;
    assign w_budget_ok  = r_granted < r_budget;
    assign w_capped     = !w_empty && w_match && (w_rd_cnt >= r_cap);
    assign w_gate       = !w_capped;
    assign w_grant      = w_gate && w_budget_ok;
    assign w_notice     = w_gate && !w_budget_ok && !r_notice_given;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_decide     = (r_state == sigrl_pkg::S_CHK) && w_final && w_out_free;

    assign w_granted_nx = r_granted + {15'd0, w_grant};
    assign w_refused_nx = r_refused + {31'd0, !w_grant};
    assign w_slots_nx   = r_slots + {{(SF_W-1){1'b0}}, (w_grant && w_empty)};
    assign w_slots_ext  = SF_X'(w_slots_nx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sigrl_pkg::S_CLEAR: begin
                if (r_idx == IDX_LAST) begin
                    n_state = sigrl_pkg::S_IDLE;
                end
            end
            sigrl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = r_mid ? sigrl_pkg::S_HBYTE : sigrl_pkg::S_HOP;
                end
            end
            sigrl_pkg::S_HOP:   n_state = sigrl_pkg::S_HCALL;
            sigrl_pkg::S_HCALL: n_state = sigrl_pkg::S_HBYTE;
            sigrl_pkg::S_HBYTE: begin
                n_state = r_last ? sigrl_pkg::S_MOD : sigrl_pkg::S_IDLE;
            end
            sigrl_pkg::S_MOD: begin
                if (r_bit == 2'd2) begin
                    n_state = sigrl_pkg::S_RD;
                end
            end
            sigrl_pkg::S_RD: n_state = sigrl_pkg::S_CHK;
            sigrl_pkg::S_CHK: begin
                if (!w_final) begin
                    n_state = sigrl_pkg::S_RD;
                end else if (w_out_free) begin
                    n_state = sigrl_pkg::S_IDLE;
                end
            end
            default: n_state = sigrl_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        w_ram_we    = 1'b0;
        w_ram_wdata = '0;
        unique case (r_state)
            sigrl_pkg::S_CLEAR: begin
                w_ram_we = 1'b1;
            end
            sigrl_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            sigrl_pkg::S_CHK: begin
                w_ram_we = w_decide && w_grant && (w_empty || w_match);
                w_ram_wdata = {r_sig, (w_empty ? 8'd1 : w_rd_cnt + 8'd1)};
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= sigrl_pkg::RST_RUN_BUDGET;
            r_cap    <= sigrl_pkg::RST_SIG_CAP;
            r_sys_op <= sigrl_pkg::RST_SYSCALL_OP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sigrl_pkg::CFG_RUN_BUDGET: r_budget <= i_cfg_wdata[15:0];
                sigrl_pkg::CFG_SIG_CAP:    r_cap    <= i_cfg_wdata[7:0];
                sigrl_pkg::CFG_SYSCALL_OP: r_sys_op <= i_cfg_wdata;
                default:                   r_sys_op <= r_sys_op;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= sigrl_pkg::S_CLEAR;
            r_idx          <= '0;
            r_mid          <= 1'b0;
            r_granted      <= '0;
            r_refused      <= '0;
            r_slots        <= '0;
            r_notice_given <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sigrl_pkg::S_CLEAR) begin
                r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            end
            if (w_accept) begin
                r_byte    <= i_in_word.name_byte;
                r_present <= i_in_word.byte_present;
                r_last    <= i_in_word.last;
                if (!r_mid) begin
                    r_mid    <= 1'b1;
                    r_hash   <= sigrl_pkg::FNV_BASIS;
                    r_op     <= i_in_word.op_type;
                    r_giveup <= 1'b0;
                    if (i_in_word.op_type != r_sys_op) begin
                        r_call <= 32'd0;
                    end else if (!i_in_word.snapshot_ok) begin
                        r_call   <= '1;
                        r_giveup <= 1'b1;
                    end else begin
                        r_call <= i_in_word.call_number;
                    end
                end
            end
            if (r_state == sigrl_pkg::S_HOP || r_state == sigrl_pkg::S_HCALL) begin
                r_hash <= w_fold;
            end
            if (r_state == sigrl_pkg::S_HBYTE) begin
                r_hash <= w_hash_end;
                if (r_last) begin
                    r_mid <= 1'b0;
                    r_sig <= (w_hash_end == 32'd0) ? 32'd1 : w_hash_end;
                    r_bit <= '0;
                end
            end
            if (r_state == sigrl_pkg::S_MOD) begin
                r_bit <= r_bit + 2'd1;
                if (r_bit == 2'd0) begin
                    r_mod <= w_recip_prod[63:32];
                end else if (r_bit == 2'd1) begin
                    r_mod <= w_mod_r0;
                end else begin
                    r_idx   <= w_mod_nx[IDX_W-1:0];
                    r_probe <= '0;
                end
            end
            if (r_state == sigrl_pkg::S_CHK && !w_final) begin
                r_idx   <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
                r_probe <= r_probe + 1'b1;
            end
            if (w_decide) begin
                r_granted   <= w_granted_nx;
                r_refused   <= w_refused_nx;
                r_slots     <= w_slots_nx;
                if (w_notice) begin
                    r_notice_given <= 1'b1;
                end
                r_out_valid <= 1'b1;
                r_out.grant_print     <= w_grant;
                r_out.budget_notice   <= w_notice;
                r_out.snapshot_giveup <= r_giveup;
                r_out.printed_count   <= w_granted_nx;
                r_out.omitted_count   <= w_refused_nx;
                r_out.signatures_used <= (w_slots_ext > SF_X'(255)) ? 8'hFF : w_slots_ext[7:0];
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // A final decision always leaves a word in the output register.
    a_decide_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_decide |=> o_out_valid)
        else $error("decision did not produce an output word");

    // The used-slot count moves only when a new signature is granted a slot.
    a_slots_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_decide && w_grant && w_empty) |=> $stable(r_slots))
        else $error("slot count changed without a new signature");

    // Every probe index, from the start slot of the remainder unit on, is inside the table.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sigrl_pkg::S_RD) |-> (32'(r_idx) < TABLE_SLOTS))
        else $error("probe index out of table range");

    // Once the budget notice has been given it is never given again.
    a_notice_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_notice_given |=> (r_notice_given && !(w_decide && w_notice)))
        else $error("budget notice repeated");

endmodule

FILE: tb/sigrl_decision_checker.sv
// Scoreboard for the signature rate limiter: mirrors its registers, signature table and
// counters, predicts each decision word and compares it with the block's output word.
// Uses sigrl_pkg; instantiated beside the block by tb_signature_rate_limiter.
module sigrl_decision_checker #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  sigrl_pkg::t_in_word                 i_in_word,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  sigrl_pkg::t_out_word                i_out_word,
    input  logic                                i_cfg_we,
    input  logic [sigrl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sigrl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output int                                  o_mismatches,
    output int                                  o_pending,
    output int                                  o_decisions,
    output int                                  o_printed
);

    logic [15:0] run_budget;
    logic [7:0]  sig_cap;
    logic [31:0] syscall_code;

    logic [31:0] sig_acc;
    bit          in_request;
    bit          giveup_latch;
    logic [31:0] slot_sig [TABLE_SLOTS];
    logic [7:0]  slot_cnt [TABLE_SLOTS];
    logic [31:0] granted_total;
    logic [31:0] refused_total;
    int          slots_filled;
    bit          notice_given;

    sigrl_pkg::t_out_word expected_decisions[$];
    int                   mismatches;
    int                   decisions;

    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
        return (h ^ v) * sigrl_pkg::FNV_PRIME;
    endfunction

    function automatic string decision_text(input sigrl_pkg::t_out_word d);
        return $sformatf("grant=%0b notice=%0b giveup=%0b printed=%0d omitted=%0d used=%0d",
                         d.grant_print, d.budget_notice, d.snapshot_giveup,
                         d.printed_count, d.omitted_count, d.signatures_used);
    endfunction

    task automatic charge_budget(output bit grant, output bit notice);
        grant  = 1'b0;
        notice = 1'b0;
        if (granted_total >= {16'd0, run_budget}) begin
            refused_total++;
            if (!notice_given) begin
                notice_given = 1'b1;
                notice       = 1'b1;
            end
        end else begin
            granted_total++;
            grant = 1'b1;
        end
    endtask

    task automatic decide_print(input logic [31:0] sig, output bit grant, output bit notice);
        int first;
        int idx;
        int k;
        bit done;
        grant  = 1'b0;
        notice = 1'b0;
        done   = 1'b0;
        first  = int'(sig % TABLE_SLOTS);
        for (k = 0; k < TABLE_SLOTS && !done; k++) begin
            idx = (first + k) % TABLE_SLOTS;
            if (slot_sig[idx] == 32'd0) begin
                charge_budget(grant, notice);
                if (grant) begin
                    slot_sig[idx] = sig;
                    slot_cnt[idx] = 8'd1;
                    slots_filled++;
                end
                done = 1'b1;
            end else if (slot_sig[idx] == sig) begin
                if (slot_cnt[idx] >= sig_cap) begin
                    refused_total++;
                end else begin
                    charge_budget(grant, notice);
                    if (grant) slot_cnt[idx] = slot_cnt[idx] + 8'd1;
                end
                done = 1'b1;
            end
        end
        if (!done) charge_budget(grant, notice);
    endtask

    task automatic predict_decision(input sigrl_pkg::t_in_word w);
        logic [31:0]          callno;
        logic [31:0]          sig;
        bit                   grant;
        bit                   notice;
        sigrl_pkg::t_out_word d;
        if (!in_request) begin
            callno       = 32'd0;
            giveup_latch = 1'b0;
            if (w.op_type == syscall_code) begin
                callno = w.call_number;
                if (!w.snapshot_ok) begin
                    callno       = '1;
                    giveup_latch = 1'b1;
                end
            end
            sig_acc    = fnv_mix(fnv_mix(sigrl_pkg::FNV_BASIS, w.op_type), callno);
            in_request = 1'b1;
        end
        if (w.byte_present) sig_acc = fnv_mix(sig_acc, {24'd0, w.name_byte});
        if (w.last) begin
            sig        = (sig_acc == 32'd0) ? 32'd1 : sig_acc;
            in_request = 1'b0;
            sig_acc    = sigrl_pkg::FNV_BASIS;
            decide_print(sig, grant, notice);
            d.grant_print     = grant;
            d.budget_notice   = notice;
            d.snapshot_giveup = giveup_latch;
            d.printed_count   = granted_total[15:0];
            d.omitted_count   = refused_total;
            d.signatures_used = (slots_filled > 255) ? 8'd255 : 8'(slots_filled);
            giveup_latch      = 1'b0;
            expected_decisions.push_back(d);
        end
    endtask

    task automatic check_decision(input sigrl_pkg::t_out_word got);
        sigrl_pkg::t_out_word want;
        decisions++;
        if (expected_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected decision word: %s", $time, decision_text(got));
        end else begin
            want = expected_decisions.pop_front();
            if (got.grant_print !== want.grant_print ||
                got.budget_notice !== want.budget_notice ||
                got.snapshot_giveup !== want.snapshot_giveup ||
                got.printed_count !== want.printed_count ||
                got.omitted_count !== want.omitted_count ||
                got.signatures_used !== want.signatures_used) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: decision mismatch", $time);
                    $display("    expected %s", decision_text(want));
                    $display("    actual   %s", decision_text(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_budget    = sigrl_pkg::RST_RUN_BUDGET;
            sig_cap       = sigrl_pkg::RST_SIG_CAP;
            syscall_code  = sigrl_pkg::RST_SYSCALL_OP;
            sig_acc       = sigrl_pkg::FNV_BASIS;
            in_request    = 1'b0;
            giveup_latch  = 1'b0;
            for (int k = 0; k < TABLE_SLOTS; k++) begin
                slot_sig[k] = 32'd0;
                slot_cnt[k] = 8'd0;
            end
            granted_total = 32'd0;
            refused_total = 32'd0;
            slots_filled  = 0;
            notice_given  = 1'b0;
            expected_decisions.delete();
            mismatches    = 0;
            decisions     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sigrl_pkg::CFG_RUN_BUDGET: run_budget   = i_cfg_wdata[15:0];
                    sigrl_pkg::CFG_SIG_CAP:    sig_cap      = i_cfg_wdata[7:0];
                    sigrl_pkg::CFG_SYSCALL_OP: syscall_code = i_cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_decision(i_in_word);
            if (i_out_valid && !i_out_stall) check_decision(i_out_word);
        end
        o_mismatches = mismatches;
        o_pending    = expected_decisions.size();
        o_decisions  = decisions;
        o_printed    = int'(granted_total);
    end

endmodule

FILE: tb/tb_signature_rate_limiter.sv
// Testbench top for the signature rate limiter: clock, reset, register writes, request
// stimulus and output back-pressure; checking is done by sigrl_decision_checker.
// Uses sigrl_pkg, signature_rate_limiter and sigrl_decision_checker.
module tb_signature_rate_limiter;

    localparam int SLOTS = 128;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    sigrl_pkg::t_in_word              in_word   = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    sigrl_pkg::t_out_word             out_word;
    logic                             cfg_we    = 1'b0;
    logic [sigrl_pkg::CFG_IDX_W-1:0]  cfg_idx   = sigrl_pkg::CFG_RUN_BUDGET;
    logic [sigrl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int          mismatches;
    int          pending;
    int          decisions;
    int          printed;
    int          words_sent  = 0;
    int          settings    = 0;
    int          burst_left  = 4;
    bit          hold_request = 1'b0;
    logic [31:0] cur_syscall = sigrl_pkg::RST_SYSCALL_OP;

    signature_rate_limiter #(.TABLE_SLOTS(SLOTS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    sigrl_decision_checker #(.TABLE_SLOTS(SLOTS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_decisions  (decisions),
        .o_printed    (printed)
    );

    always #5 clk = ~clk;

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Op type that drives a one-byte, non-syscall request to the given final signature.
    function automatic logic [31:0] op_for_signature(input logic [31:0] final_sig,
                                                     input logic [7:0] b);
        logic [31:0] inv;
        logic [31:0] folded;
        inv = sigrl_pkg::FNV_PRIME;
        repeat (5) inv = inv * (32'd2 - sigrl_pkg::FNV_PRIME * inv);
        folded = (final_sig * inv) ^ {24'd0, b};
        return sigrl_pkg::FNV_BASIS ^ (folded * inv * inv);
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_item(input logic [31:0] op, input logic [31:0] call, input bit ok,
                             input logic [7:0] b, input bit present, input bit is_last);
        sigrl_pkg::t_in_word w;
        w.op_type      = op;
        w.call_number  = call;
        w.snapshot_ok  = ok;
        w.name_byte    = b;
        w.byte_present = present;
        w.last         = is_last;
        @(negedge clk);
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic drain_results();
        idle_cycles(1);
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [sigrl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_registers(input logic [15:0] budget, input logic [7:0] cap,
                                 input logic [31:0] sc);
        cfg_write(sigrl_pkg::CFG_RUN_BUDGET, {16'd0, budget});
        cfg_write(sigrl_pkg::CFG_SIG_CAP, {24'd0, cap});
        cfg_write(sigrl_pkg::CFG_SYSCALL_OP, sc);
        cur_syscall = sc;
        settings++;
    endtask

    // Half of the requests come from a small set of names and headers so that
    // signatures repeat and run into the per-signature cap.
    task automatic send_request(input bit paced);
        bit          pooled;
        int          name_id;
        int          n;
        logic [31:0] op;
        logic [31:0] call;
        bit          ok;
        logic [7:0]  b;
        bit          present;
        pooled  = 1'($urandom_range(0, 1));
        name_id = $urandom_range(0, 5);
        if (pooled)
            n = 1 + name_id % 3;
        else
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
            op      = $urandom;
            call    = $urandom;
            ok      = 1'($urandom_range(0, 1));
            b       = 8'($urandom);
            present = ($urandom_range(0, 9) != 0);
            if (pooled) begin
                b       = 8'h61 + 8'(name_id) + 8'(k);
                present = 1'b1;
                if (k == 0) begin
                    case ($urandom_range(0, 3))
                        0:       op = cur_syscall;
                        1:       op = 32'd1;
                        2:       op = 32'h8000_0000;
                        default: op = ~cur_syscall;
                    endcase
                    call = $urandom_range(0, 2);
                    ok   = ($urandom_range(0, 5) != 0);
                end
            end else if (k == 0 && $urandom_range(0, 2) == 0) begin
                op = cur_syscall;
            end
            send_item(op, call, ok, b, present, k == n - 1);
            if (paced) begin
                burst_left--;
                if (burst_left <= 0) begin
                    idle_cycles($urandom_range(1, 10));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(1, 8);
                end
            end
        end
    endtask

    task automatic random_phase(input int n_words);
        int target;
        target = words_sent + n_words;
        while (words_sent < target) send_request(1'b1);
        drain_results();
    endtask

    initial begin : receiver
        int mode;
        int span;
        int hold_left;
        int tick;
        hold_left = 0;
        tick      = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 200);
            repeat (span) begin
                @(negedge clk);
                if (hold_request) begin
                    hold_request = 1'b0;
                    hold_left    = 400;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    out_stall <= 1'b1;
                end else begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= (tick % 5 < 2);
                    endcase
                end
                tick++;
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_registers(16'd256, 8'd2, 32'h0000_003B);
        repeat (3) begin
            send_item(32'h3B, 32'd1, 1'b1, 8'h61, 1'b1, 1'b0);
            send_item($urandom, $urandom, 1'($urandom_range(0, 1)), 8'h62, 1'b1, 1'b1);
        end
        send_item(32'h3B, 32'd7, 1'b0, 8'h78, 1'b1, 1'b1);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b1, 1'b1);
        send_item(32'd0, 32'd0, 1'b1, 8'h00, 1'b1, 1'b1);
        send_item(32'h3B, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, 1'b1);
        send_item(32'h8000_0000, 32'h55AA_55AA, 1'b1, 8'h10, 1'b1, 1'b0);
        send_item($urandom, $urandom, 1'b1, 8'h20, 1'b0, 1'b0);
        send_item($urandom, $urandom, 1'b0, 8'h30, 1'b1, 1'b1);
        // A request whose hash comes out zero, then one that hashes to one:
        // both must land on the same signature.
        send_item(op_for_signature(32'd0, 8'h5C), $urandom, 1'($urandom_range(0, 1)),
                  8'h5C, 1'b1, 1'b1);
        send_item(op_for_signature(32'd1, 8'hA3), $urandom, 1'($urandom_range(0, 1)),
                  8'hA3, 1'b1, 1'b1);
        drain_results();

        set_registers(16'd0, 8'd2, 32'h0000_003B);
        send_item(32'd1, 32'd0, 1'b1, 8'h41, 1'b1, 1'b1);
        send_item(32'd1, 32'd0, 1'b1, 8'h41, 1'b1, 1'b1);
        send_item(32'hFFFF_FFFF, 32'd0, 1'b1, 8'hFF, 1'b1, 1'b1);
        drain_results();

        set_registers(16'hFFFF, 8'd255, 32'd2);
        hold_request = 1'b1;
        repeat (10) send_request(1'b0);
        drain_results();
        random_phase(170);

        set_registers(16'hFFFF, 8'd1, 32'hFFFF_FFFF);
        random_phase(150);

        set_registers(16'(printed + 25), sigrl_pkg::RST_SIG_CAP, sigrl_pkg::RST_SYSCALL_OP);
        random_phase(150);

        set_registers(16'hFFFF, 8'd128, $urandom);
        random_phase(140);

        repeat (300) @(negedge clk);
        $display("Run covered %0d request words and %0d decisions (%0d prints granted)",
                 words_sent, decisions, printed);
        $display("over %0d register settings, including zero and full budget and caps 1 to 255.",
                 settings);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
